### rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int OP_W          = 3;
  localparam int DATA_W        = 32;
  localparam int COUNT_OUT_W   = 11;
  localparam int STATUS_W      = 2;
  localparam int S_TDATA_W     = 32;
  localparam int S_TUSER_W     = 8;
  localparam int M_TDATA_W     = 48;
  localparam int M_TUSER_W     = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SIZE       = 3'd4,
    OP_EMPTY      = 3'd5,
    OP_FRONT      = 3'd6,
    OP_BACK       = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;   // latch the incoming item
    logic exec;      // pointer update and memory access
    logic load_out;  // move result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } dp_status_t;

endpackage

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps

// Channel  Dir  Bus                 Fields (lowest bit first)
// s_axis   in   tdata[31:0]         push_value
//               tuser[7:0]          operation[2:0], zero fill
// m_axis   out  tdata[47:0]         read_value[31:0], item_count[42:32], is_empty[43]
//               tuser[7:0]          status[1:0], zero fill
//
// Each item passes through accept, pointer update with one store access, then
// load of the result register; the single-port store's registered read sets this.
// The result register frees the input side, so a new item is taken while a
// result still waits for m_tready; a stalled result blocks only the next load.
// rst is synchronous: queue empty, pointers zero, no result pending.

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // push_value
  input  logic [S_TUSER_W-1:0] s_tuser,   // operation, zeros
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // read_value, item_count, is_empty, zeros
  output logic [M_TUSER_W-1:0] m_tuser    // status, zeros
);

  ctrl_cmd_t               cmd;
  dp_status_t              status;
  logic [DATA_W-1:0]       read_value;
  logic [COUNT_OUT_W-1:0]  item_count;
  logic                    is_empty;
  logic [STATUS_W-1:0]     res_status;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  deq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_op          (s_tuser[OP_W-1:0]),
    .in_value       (s_tdata[DATA_W-1:0]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_read_value (read_value),
    .out_item_count (item_count),
    .out_is_empty   (is_empty),
    .out_status     (res_status)
  );

  assign m_tdata = {4'b0, is_empty, item_count, read_value};
  assign m_tuser = {6'b0, res_status};

endmodule

### rtl/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl
  import deq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/deq_dpath.sv
`timescale 1ns / 1ps

module deq_dpath
  import deq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic [OP_W-1:0]         in_op,
  input  logic [DATA_W-1:0]       in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DATA_W-1:0]       out_read_value,
  output logic [COUNT_OUT_W-1:0]  out_item_count,
  output logic                    out_is_empty,
  output logic [STATUS_W-1:0]     out_status
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  logic [DATA_W-1:0] store [QUEUE_DEPTH];

  op_t               op;
  logic [DATA_W-1:0] value;
  logic [AW-1:0]     front;
  logic [AW-1:0]     back;
  logic [CW-1:0]     count;
  logic [DATA_W-1:0] rd_data;
  status_t           res_status;
  logic              res_from_mem;

  logic [AW-1:0] front_next;
  logic [AW-1:0] back_next;
  logic [CW-1:0] count_next;
  logic [AW-1:0] addr;
  logic          we;
  logic          use_mem;
  status_t       st;
  logic [AW-1:0] front_up;
  logic [AW-1:0] front_down;
  logic [AW-1:0] back_up;
  logic [AW-1:0] back_down;
  logic          is_full;
  logic          no_words;

  assign front_up   = (front == LAST_SLOT) ? '0 : front + 1'b1;
  assign front_down = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign back_up    = (back == LAST_SLOT) ? '0 : back + 1'b1;
  assign back_down  = (back == '0) ? LAST_SLOT : back - 1'b1;
  assign is_full    = (count == FULL_COUNT);
  assign no_words   = (count == '0);

  always_comb begin
    front_next = front;
    back_next  = back;
    count_next = count;
    addr       = front;
    we         = 1'b0;
    use_mem    = 1'b0;
    st         = ST_OK;
    unique case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (is_full) begin
          st = ST_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + 1'b1;
          if (op == OP_PUSH_BACK) begin
            addr      = back;
            back_next = back_up;
          end else begin
            addr       = front_down;
            front_next = front_down;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_FRONT, OP_BACK: begin
        if (no_words) begin
          st = ST_EMPTY;
        end else begin
          use_mem = 1'b1;
          if (op == OP_POP_FRONT || op == OP_FRONT) begin
            addr = front;
          end else begin
            addr = back_down;
          end
          if (op == OP_POP_FRONT) begin
            front_next = front_up;
            count_next = count - 1'b1;
          end else if (op == OP_POP_BACK) begin
            back_next  = back_down;
            count_next = count - 1'b1;
          end
        end
      end
      OP_SIZE, OP_EMPTY: begin
        st = ST_OK;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // single-port store, registered read; read data held until the result loads
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (we) begin
        store[addr] <= value;
      end
      rd_data <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= op_t'(in_op);
      value <= in_value;
    end
    if (cmd.exec) begin
      res_status   <= st;
      res_from_mem <= use_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

  // output register decouples the result side from the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (res_from_mem) begin
        out_read_value <= rd_data;
      end else if (res_status == ST_EMPTY) begin
        out_read_value <= '1;
      end else begin
        out_read_value <= '0;
      end
      out_item_count <= COUNT_OUT_W'(count);
      out_is_empty   <= no_words;
      out_status     <= res_status;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule
